### rtl/tte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table engine package
// Shared payload types, table entry layout and command codes.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam logic [1:0] CMD_PROBE = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [1:0] KIND_EXACT = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;

  localparam logic [7:0]  EMPTY_DRAFT        = 8'hFF;
  localparam logic [14:0] MATE_THRESHOLD_RST = 15'd30000;
  localparam logic signed [17:0] SCORE_MAX   = 18'sd32767;
  localparam logic signed [17:0] SCORE_MIN   = -18'sd32767;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [63:0]        key;
    logic [6:0]         draft;
    logic [7:0]         ply;
    logic signed [15:0] value;
    logic [15:0]        move_code;
    logic [1:0]         bound_kind;
    logic signed [15:0] window_low;
    logic signed [15:0] window_high;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic               cutoff;
    logic signed [15:0] found_value;
    logic [15:0]        found_move;
    logic               written;
  } out_t;

  // One table entry; draft is two's complement so that an empty entry holds -1.
  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         draft;
    logic signed [15:0] score;
    logic [15:0]        move;
    logic [1:0]         kind;
  } entry_t;

  localparam entry_t EMPTY_ENTRY = '{key: 64'd0, draft: EMPTY_DRAFT, score: 16'sd0,
                                     move: 16'd0, kind: KIND_EXACT};

endpackage

### rtl/tte_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table memory
// Entry array with separate write and read ports; the read is registered.
// ----------------------------------------------------------------------------
module tte_mem
  import tte_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  wr_en_i,
  input  logic [INDEX_BITS-1:0] wr_addr_i,
  input  entry_t                wr_data_i,
  input  logic                  rd_en_i,
  input  logic [INDEX_BITS-1:0] rd_addr_i,
  output entry_t                rd_data_o
);

  localparam int Depth = 1 << INDEX_BITS;

  entry_t mem_q [Depth];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/tte_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table evaluation
// Probe hit and cutoff decision, store replacement and mate score adjustment.
// ----------------------------------------------------------------------------
module tte_eval
  import tte_pkg::*;
(
  input  in_t         item_i,
  input  entry_t      entry_i,
  input  logic [14:0] mate_threshold_i,
  output out_t        result_o,
  output logic        wr_en_o,
  output entry_t      wr_entry_o
);

  logic signed [17:0] thr_pos;
  logic signed [17:0] thr_neg;
  logic signed [17:0] ply_ext;
  logic signed [17:0] probe_raw;
  logic signed [17:0] probe_adj;
  logic signed [15:0] probe_score;
  logic signed [17:0] store_raw;
  logic signed [17:0] store_adj;
  logic signed [15:0] wr_score;
  logic               key_match;
  logic               deep_enough;
  logic               kind_cut;
  logic               replace;

  assign thr_pos = $signed({3'b000, mate_threshold_i});
  assign thr_neg = -thr_pos;
  assign ply_ext = $signed({10'd0, item_i.ply});

  // Probe: stored mate scores move back toward the current ply.
  assign probe_raw = 18'(entry_i.score);
  always_comb begin
    if (probe_raw >= thr_pos) begin
      probe_adj = probe_raw - ply_ext;
    end else if (probe_raw <= thr_neg) begin
      probe_adj = probe_raw + ply_ext;
    end else begin
      probe_adj = probe_raw;
    end
    if (probe_adj > SCORE_MAX) begin
      probe_score = SCORE_MAX[15:0];
    end else if (probe_adj < SCORE_MIN) begin
      probe_score = SCORE_MIN[15:0];
    end else begin
      probe_score = probe_adj[15:0];
    end
  end

  // Store: mate scores move away from the ply before they are written.
  assign store_raw = 18'(item_i.value);
  always_comb begin
    if (store_raw >= thr_pos) begin
      store_adj = store_raw + ply_ext;
    end else if (store_raw <= thr_neg) begin
      store_adj = store_raw - ply_ext;
    end else begin
      store_adj = store_raw;
    end
    if (store_adj > SCORE_MAX) begin
      wr_score = SCORE_MAX[15:0];
    end else if (store_adj < SCORE_MIN) begin
      wr_score = SCORE_MIN[15:0];
    end else begin
      wr_score = store_adj[15:0];
    end
  end

  assign key_match   = (entry_i.key == item_i.key);
  assign deep_enough = $signed(entry_i.draft) >= $signed({1'b0, item_i.draft});

  always_comb begin
    case (entry_i.kind)
      KIND_EXACT: kind_cut = 1'b1;
      KIND_LOWER: kind_cut = (probe_score >= item_i.window_high);
      KIND_UPPER: kind_cut = (probe_score <= item_i.window_low);
      default:    kind_cut = 1'b0;
    endcase
  end

  assign replace = !key_match || ($signed({1'b0, item_i.draft}) >= $signed(entry_i.draft));

  always_comb begin
    result_o = '0;
    wr_en_o  = 1'b0;
    case (item_i.cmd)
      CMD_PROBE: begin
        if (key_match) begin
          result_o.hit         = 1'b1;
          result_o.cutoff      = deep_enough && kind_cut;
          result_o.found_value = probe_score;
          result_o.found_move  = entry_i.move;
        end
      end
      CMD_STORE: begin
        wr_en_o          = replace;
        result_o.written = replace;
      end
      default: begin
      end
    endcase
  end

  assign wr_entry_o = '{key: item_i.key, draft: {1'b0, item_i.draft}, score: wr_score,
                        move: item_i.move_code, kind: item_i.bound_kind};

endmodule

### rtl/transposition_table_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table engine
// Direct-mapped table with probe, store and whole-table clear.
// ----------------------------------------------------------------------------
// Probe and store: table read (ST_READ), then evaluate and write back
// (ST_EVAL), held while the output stalls; one transaction is in flight.
// A store to another key always replaces; to the same key, only at equal
// or greater draft. Clear: one entry per cycle, then a result. After reset
// the same sweep runs, without a result, before the first transaction is
// accepted; configuration writes are taken at any time.
module transposition_table_engine_unit
  import tte_pkg::*;
#(
  parameter int INDEX_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_READ   = 3'd2;
  localparam logic [2:0] ST_EVAL   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [INDEX_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic                  clr_report_q, clr_report_d;
  logic [14:0]           mate_threshold_q;
  in_t                   item_q;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;

  logic                  out_free;
  logic                  accept;
  logic [INDEX_BITS-1:0] item_index;
  entry_t                rd_entry;
  out_t                  eval_result;
  logic                  eval_wr_en;
  entry_t                eval_entry;
  logic                  mem_we;
  logic [INDEX_BITS-1:0] mem_waddr;
  entry_t                mem_wdata;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign item_index = item_q.key[INDEX_BITS-1:0];

  // Only one transaction is in flight, so a read never overlaps a write.
  tte_mem #(
    .INDEX_BITS(INDEX_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (mem_waddr),
    .wr_data_i (mem_wdata),
    .rd_en_i   (state_q == ST_READ),
    .rd_addr_i (item_index),
    .rd_data_o (rd_entry)
  );

  tte_eval u_eval (
    .item_i           (item_q),
    .entry_i          (rd_entry),
    .mate_threshold_i (mate_threshold_q),
    .result_o         (eval_result),
    .wr_en_o          (eval_wr_en),
    .wr_entry_o       (eval_entry)
  );

  always_comb begin
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = EMPTY_ENTRY;
    end else begin
      mem_we    = (state_q == ST_EVAL) && out_free && eval_wr_en;
      mem_waddr = item_index;
      mem_wdata = eval_entry;
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    clr_report_d = clr_report_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = clr_report_q ? ST_FINISH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd == CMD_CLEAR) begin
            state_d      = ST_CLEAR;
            clr_report_d = 1'b1;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = eval_result;
          state_d     = ST_IDLE;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.written       = 1'b1;
          clr_report_d        = 1'b0;
          state_d             = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_CLEAR;
      clr_cnt_q        <= '0;
      clr_report_q     <= 1'b0;
      out_valid_q      <= 1'b0;
      mate_threshold_q <= MATE_THRESHOLD_RST;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_report_q <= clr_report_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        mate_threshold_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
